// ----- hdl/gtps_pkg.sv -----
`default_nettype none
package gtps_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam int POS_W = 24;
	localparam int ANG_W = 16;
	localparam int DIF_W = POS_W + 1;
	localparam int CRD_W = POS_W + 4;
	localparam int ZW = 32;
	localparam int RAD_W = 25;
	localparam int ACC_W = 34;

	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 19;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 23;

	localparam logic signed [MUL_B_W-1:0] K_MAG = 19'sd39797;
	localparam logic signed [MUL_B_W-1:0] K_TURN = 19'sd205887;
	localparam logic [16:0] BEARING_LIMIT = 17'd3640;
	localparam logic [16:0] HEADING_LIMIT = 17'd1043;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_POSE  = 2'd1,
		OP_STOP  = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TS_INIT = 2'd0,
		TS_RUN  = 2'd1,
		TS_DONE = 2'd2,
		TS_TERM = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ARRIVE  = 3'd0,
		REG_SPEED_G = 3'd1,
		REG_BEAR_G  = 3'd2,
		REG_HEAD_G  = 3'd3,
		REG_SPEED_L = 3'd4,
		REG_TURN_L  = 3'd5,
		REG_HEAD_T  = 3'd6,
		REG_NONE    = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORD,
		ST_MAG,
		ST_RND,
		ST_VEL,
		ST_BG,
		ST_HG,
		ST_SUM,
		ST_TRN,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
	} cord_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cord_sts_t;

	function automatic logic [ZW-1:0] atan_at(input logic [4:0] idx);
		logic [ZW-1:0] v;
		case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		logic signed [16:0] e;
		e = {v[15], v};
		return (e < 0) ? 17'(-e) : 17'(e);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/gtps_mul.sv -----
`default_nettype none
module gtps_mul import gtps_pkg::*; (
	input  logic                       clk,
	input  logic signed [MUL_A_W-1:0]  a,
	input  logic signed [MUL_B_W-1:0]  b,
	output logic signed [PROD_W-1:0]   prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// ----- hdl/gtps_cordic.sv -----
`default_nettype none
module gtps_cordic import gtps_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cord_ctl_t                ctl,
	input  logic signed [DIF_W-1:0]  dx,
	input  logic signed [DIF_W-1:0]  dy,
	output cord_sts_t                sts,
	output logic signed [CRD_W-1:0]  mag,
	output logic [ZW-1:0]            angle
);

	localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

	logic                    busy_q;
	logic                    done_q;
	logic                    zero_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [CRD_W-1:0] x_q;
	logic signed [CRD_W-1:0] y_q;
	logic [ZW-1:0]           z_q;

	logic signed [CRD_W-1:0] dx_e;
	logic signed [CRD_W-1:0] dy_e;
	logic signed [CRD_W-1:0] xs;
	logic signed [CRD_W-1:0] ys;
	logic [ZW-1:0]           at;

	assign dx_e = CRD_W'(dx);
	assign dy_e = CRD_W'(dy);
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = atan_at(5'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				zero_q <= (dx == '0) && (dy == '0);
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			if (dx_e < 0) begin
				x_q <= -dx_e;
				y_q <= -dy_e;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= dx_e;
				y_q <= dy_e;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign mag = zero_q ? '0 : x_q;
	assign angle = zero_q ? '0 : z_q;

endmodule
`default_nettype wire

// ----- hdl/go_to_pose_steering.sv -----
// Go-to-pose steering for a unicycle robot. A start transaction stores the
// target pose (optionally offset by the current position) and the mode and
// answers with status initialised; a stop (or spare) transaction answers
// with a zero command and status terminated. A pose transaction runs one
// CORDIC vectoring pass, one rotation per cycle for CORDIC_STEPS rotations,
// to get distance and bearing, then eight more sequencer steps on a single
// shared 35x19 multiplier for magnitude scaling, speed and the turn law. A
// pose result is registered in the last sequencer step; any other result
// appears in the cycle after acceptance, and the input is ready again in
// the cycle after the result is taken. The user must write configuration
// registers through cfg_we / cfg_index / cfg_data only while idle (the block does not enforce this).
`default_nettype none
module go_to_pose_steering import gtps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic signed [23:0]    pos_x,
	input  logic signed [23:0]    pos_y,
	input  logic signed [15:0]    heading,
	input  logic signed [23:0]    goal_x,
	input  logic signed [23:0]    goal_y,
	input  logic signed [15:0]    goal_heading,
	input  logic                  relative_goal,
	input  logic                  combined_mode,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [14:0]           linear_speed,
	output logic signed [15:0]    turn_rate,
	output logic                  command_valid,
	output logic [1:0]            task_status
);

	state_t state_q;
	state_t state_d;

	logic [22:0] arrive_distance_q;
	logic [15:0] speed_gain_q;
	logic [15:0] bearing_gain_q;
	logic [15:0] heading_gain_q;
	logic [14:0] speed_limit_q;
	logic [14:0] turn_limit_q;
	logic [14:0] heading_tolerance_q;

	logic signed [POS_W-1:0] tgt_x_q;
	logic signed [POS_W-1:0] tgt_y_q;
	logic signed [ANG_W-1:0] tgt_h_q;
	logic                    mode_q;

	logic signed [ANG_W-1:0] th_q;
	logic [RAD_W-1:0]        r_q;
	logic signed [ANG_W-1:0] alpha_q;
	logic signed [ANG_W-1:0] gamma_q;
	logic [14:0]             vel_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [14:0]        spd_q;
	logic signed [15:0] turn_q;
	logic               cmd_q;
	logic [1:0]         status_q;

	cord_ctl_t               cctl;
	cord_sts_t               csts;
	logic signed [DIF_W-1:0] dx;
	logic signed [DIF_W-1:0] dy;
	logic signed [CRD_W-1:0] cmag;
	logic [ZW-1:0]           cang;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;

	logic                    accept;
	logic [41:0]             rsum;
	logic [ZW-1:0]           bsum;
	logic [34:0]             vprod;
	logic signed [PROD_W-1:0] tsum;
	logic signed [26:0]      tsh;
	logic signed [26:0]      lim27;
	logic signed [15:0]      tclamp;
	logic signed [15:0]      tl_pos;
	logic signed [15:0]      tl_neg;
	logic signed [ANG_W-1:0] hdg_err;
	logic                    near;
	logic [14:0]             fin_spd;
	logic signed [15:0]      fin_turn;
	logic                    fin_cmd;
	logic [1:0]              fin_status;

	assign accept = in_valid && in_ready;
	assign dx = DIF_W'(tgt_x_q) - DIF_W'(pos_x);
	assign dy = DIF_W'(tgt_y_q) - DIF_W'(pos_y);

	gtps_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.dx     (dx),
		.dy     (dy),
		.sts    (csts),
		.mag    (cmag),
		.angle  (cang)
	);

	gtps_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (operation == OP_POSE) ? ST_CORD : ST_OUT;
				end
			end
			ST_CORD: begin
				if (csts.done) begin
					state_d = ST_MAG;
				end
			end
			ST_MAG: state_d = ST_RND;
			ST_RND: state_d = ST_VEL;
			ST_VEL: state_d = ST_BG;
			ST_BG:  state_d = ST_HG;
			ST_HG:  state_d = ST_SUM;
			ST_SUM: state_d = ST_TRN;
			ST_TRN: state_d = ST_FIN;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		cctl.start = in_valid && (state_q == ST_IDLE) && (operation == OP_POSE);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MAG: begin
				mul_a = MUL_A_W'(cmag);
				mul_b = K_MAG;
			end
			ST_VEL: begin
				mul_a = {10'b0, r_q};
				mul_b = {3'b0, speed_gain_q};
			end
			ST_BG: begin
				mul_a = MUL_A_W'(alpha_q);
				mul_b = {3'b0, bearing_gain_q};
			end
			ST_HG: begin
				mul_a = MUL_A_W'(gamma_q);
				mul_b = {3'b0, heading_gain_q};
			end
			ST_TRN: begin
				mul_a = MUL_A_W'(acc_q);
				mul_b = K_TURN;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrive_distance_q <= 23'd102;
			speed_gain_q <= 16'd256;
			bearing_gain_q <= 16'd256;
			heading_gain_q <= 16'd0;
			speed_limit_q <= 15'd4096;
			turn_limit_q <= 15'd4096;
			heading_tolerance_q <= 15'd1043;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ARRIVE:  arrive_distance_q <= cfg_data;
				REG_SPEED_G: speed_gain_q <= cfg_data[15:0];
				REG_BEAR_G:  bearing_gain_q <= cfg_data[15:0];
				REG_HEAD_G:  heading_gain_q <= cfg_data[15:0];
				REG_SPEED_L: speed_limit_q <= cfg_data[14:0];
				REG_TURN_L:  turn_limit_q <= cfg_data[14:0];
				REG_HEAD_T:  heading_tolerance_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			tgt_h_q <= '0;
			mode_q <= 1'b0;
		end else if (accept && (operation == OP_START)) begin
			tgt_x_q <= relative_goal ? goal_x + pos_x : goal_x;
			tgt_y_q <= relative_goal ? goal_y + pos_y : goal_y;
			tgt_h_q <= goal_heading;
			mode_q <= combined_mode;
		end
	end

	always_comb begin
		rsum = prod[41:0] + 42'd32768;
		bsum = cang + 32'h0000_8000;
		vprod = prod[40:6];
		tsum = prod + PROD_W'(64'sd67108864);
		tsh = tsum[PROD_W-1:27];
		lim27 = {12'b0, turn_limit_q};
		tl_pos = {1'b0, turn_limit_q};
		tl_neg = -tl_pos;
		if (tsh > lim27) begin
			tclamp = tl_pos;
		end else if (tsh < -lim27) begin
			tclamp = tl_neg;
		end else begin
			tclamp = tsh[15:0];
		end
		hdg_err = tgt_h_q - th_q;
		near = r_q < {2'b0, arrive_distance_q};
		fin_spd = '0;
		fin_turn = '0;
		fin_cmd = 1'b1;
		fin_status = TS_RUN;
		if (!mode_q) begin
			if (near) begin
				if (abs16(hdg_err) > HEADING_LIMIT) begin
					fin_turn = (hdg_err > 0) ? tl_pos : tl_neg;
				end else begin
					fin_cmd = 1'b0;
					fin_status = TS_DONE;
				end
			end else if (abs16(alpha_q) > BEARING_LIMIT) begin
				fin_turn = (alpha_q > 0) ? tl_pos : tl_neg;
			end else begin
				fin_spd = vel_q;
				fin_turn = tclamp;
			end
		end else begin
			if (near) begin
				if (abs16(gamma_q) < {2'b0, heading_tolerance_q}) begin
					fin_status = TS_DONE;
				end else begin
					fin_cmd = 1'b0;
				end
			end else begin
				fin_spd = vel_q;
				fin_turn = tclamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			th_q <= heading;
			if (operation == OP_START) begin
				spd_q <= '0;
				turn_q <= '0;
				cmd_q <= 1'b0;
				status_q <= TS_INIT;
			end else begin
				spd_q <= '0;
				turn_q <= '0;
				cmd_q <= 1'b1;
				status_q <= TS_TERM;
			end
		end
		case (state_q)
			ST_RND: begin
				r_q <= rsum[40:16];
				alpha_q <= bsum[31:16] - th_q;
			end
			ST_VEL: gamma_q <= tgt_h_q - th_q - alpha_q;
			ST_BG:  vel_q <= (vprod > {20'b0, speed_limit_q}) ? speed_limit_q : vprod[14:0];
			ST_HG:  acc_q <= prod[ACC_W-1:0];
			ST_SUM: begin
				if (mode_q) begin
					acc_q <= acc_q + prod[ACC_W-1:0];
				end
			end
			ST_FIN: begin
				spd_q <= fin_spd;
				turn_q <= fin_turn;
				cmd_q <= fin_cmd;
				status_q <= fin_status;
			end
			default: ;
		endcase
	end

	assign linear_speed = spd_q;
	assign turn_rate = turn_q;
	assign command_valid = cmd_q;
	assign task_status = status_q;

	a_no_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !command_valid |-> linear_speed == '0 && turn_rate == '0)
		else $error("result without command carries nonzero speed or turn");

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a result is pending");

	a_cordic_owned: assert property (@(posedge clk) disable iff (!arst_n)
		csts.busy || csts.done |-> state_q == ST_CORD)
		else $error("vectoring unit active outside its sequencer step");

	a_quick_ops: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation != OP_POSE |=> out_valid)
		else $error("start or stop result not presented on the next cycle");

	a_init_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && task_status == TS_INIT |-> !command_valid)
		else $error("start result carries a command");

endmodule
`default_nettype wire

// ----- bench/go_to_pose_steering_test.sv -----
`timescale 1ns / 100ps
module go_to_pose_steering_test import gtps_pkg::*; ();

	localparam real PI = 3.14159265358979;
	localparam int BEARING_SLACK = 3640;
	localparam int HEADING_SLACK = 1043;

	typedef struct packed {
		logic [14:0]        speed;
		logic signed [15:0] turn;
		logic               cmd;
		status_t            status;
	} steer_cmd_t;

	class steer_ledger;
		int unsigned arrive_dist = 102;
		int unsigned speed_gain = 256;
		int unsigned bear_gain = 256;
		int unsigned head_gain = 0;
		int unsigned speed_lim = 4096;
		int unsigned turn_lim = 4096;
		int unsigned head_tol = 1043;
		logic signed [23:0] tgt_x = '0;
		logic signed [23:0] tgt_y = '0;
		logic signed [15:0] tgt_h = '0;
		bit combined = 0;
		steer_cmd_t owed[$];
		int errors = 0;
		int unsigned atan_lut[24] = '{
			536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215,
			2608, 1304, 652, 326, 163, 81
		};

		function int pending();
			return owed.size();
		endfunction

		function void set_reg(reg_idx_t idx, logic [22:0] d);
			case (idx)
				REG_ARRIVE:  arrive_dist = 32'(d);
				REG_SPEED_G: speed_gain = 32'(d[15:0]);
				REG_BEAR_G:  bear_gain = 32'(d[15:0]);
				REG_HEAD_G:  head_gain = 32'(d[15:0]);
				REG_SPEED_L: speed_lim = 32'(d[14:0]);
				REG_TURN_L:  turn_lim = 32'(d[14:0]);
				REG_HEAD_T:  head_tol = 32'(d[14:0]);
				default: ;
			endcase
		endfunction

		function int mag(logic signed [15:0] v);
			int w;
			w = int'(v);
			return (w < 0) ? -w : w;
		endfunction

		function longint clamp_turn(longint g);
			longint t;
			longint lim;
			lim = longint'(turn_lim);
			t = (g * 205887 + 67108864) >>> 27;
			if (t > lim) t = lim;
			if (t < -lim) t = -lim;
			return t;
		endfunction

		function void owe(longint spd, longint trn, bit cv, status_t st);
			steer_cmd_t c;
			c.speed = spd[14:0];
			c.turn = trn[15:0];
			c.cmd = cv;
			c.status = st;
			owed.push_back(c);
		endfunction

		function void log_request(op_t op, logic signed [23:0] px, logic signed [23:0] py,
				logic signed [15:0] th, logic signed [23:0] gx, logic signed [23:0] gy,
				logic signed [15:0] gh, logic rel, logic cm);
			longint x, y, xs, ys, r, vel, g, lim;
			bit [31:0] z, zr;
			logic signed [15:0] bearing, alpha, gamma, herr;
			bit near;
			int i;
			if (op == OP_START) begin
				tgt_x = rel ? gx + px : gx;
				tgt_y = rel ? gy + py : gy;
				tgt_h = gh;
				combined = cm;
				owe(0, 0, 0, TS_INIT);
			end else if (op != OP_POSE) begin
				owe(0, 0, 1, TS_TERM);
			end else begin
				x = longint'(tgt_x) - longint'(px);
				y = longint'(tgt_y) - longint'(py);
				z = '0;
				r = 0;
				if (x != 0 || y != 0) begin
					if (x < 0) begin
						x = -x;
						y = -y;
						z = 32'h8000_0000;
					end
					for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
						xs = x >>> i;
						ys = y >>> i;
						if (y > 0) begin
							x += ys;
							y -= xs;
							z += atan_lut[i];
						end else begin
							x -= ys;
							y += xs;
							z -= atan_lut[i];
						end
					end
					r = (x * 39797 + 32768) >>> 16;
				end
				zr = z + 32'h8000;
				bearing = zr[31:16];
				alpha = bearing - th;
				near = r < longint'(arrive_dist);
				vel = (longint'(speed_gain) * r) >>> 6;
				if (vel > longint'(speed_lim)) vel = longint'(speed_lim);
				lim = longint'(turn_lim);
				if (!combined) begin
					herr = tgt_h - th;
					if (near) begin
						if (mag(herr) > HEADING_SLACK)
							owe(0, (herr > 0) ? lim : -lim, 1, TS_RUN);
						else
							owe(0, 0, 0, TS_DONE);
					end else if (mag(alpha) > BEARING_SLACK) begin
						owe(0, (alpha > 0) ? lim : -lim, 1, TS_RUN);
					end else begin
						owe(vel, clamp_turn(longint'(bear_gain) * longint'(alpha)), 1, TS_RUN);
					end
				end else begin
					gamma = tgt_h - th - alpha;
					if (near) begin
						if (mag(gamma) < int'(head_tol))
							owe(0, 0, 1, TS_DONE);
						else
							owe(0, 0, 0, TS_RUN);
					end else begin
						g = longint'(bear_gain) * longint'(alpha)
							+ longint'(head_gain) * longint'(gamma);
						owe(vel, clamp_turn(g), 1, TS_RUN);
					end
				end
			end
		endfunction

		function void check_command(logic [14:0] spd, logic signed [15:0] trn, logic cv,
				logic [1:0] st);
			steer_cmd_t w;
			if (owed.size() == 0) begin
				$error("result transaction with nothing outstanding");
				errors++;
				return;
			end
			w = owed.pop_front();
			if (spd !== w.speed) begin
				$error("linear_speed: expected %0d, got %0d", w.speed, spd);
				errors++;
			end
			if (trn !== w.turn) begin
				$error("turn_rate: expected %0d, got %0d", w.turn, trn);
				errors++;
			end
			if (cv !== w.cmd) begin
				$error("command_valid: expected %0d, got %0d", w.cmd, cv);
				errors++;
			end
			if (st !== w.status) begin
				$error("task_status: expected %0d, got %0d", w.status, st);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] operation;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [15:0] heading;
	logic signed [23:0] goal_x;
	logic signed [23:0] goal_y;
	logic signed [15:0] goal_heading;
	logic relative_goal;
	logic combined_mode;
	logic out_valid;
	logic out_ready;
	logic [14:0] linear_speed;
	logic signed [15:0] turn_rate;
	logic command_valid;
	logic [1:0] task_status;

	steer_ledger sb = new();
	bit steady = 0;
	int sent = 0;

	go_to_pose_steering u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.heading       (heading),
		.goal_x        (goal_x),
		.goal_y        (goal_y),
		.goal_heading  (goal_heading),
		.relative_goal (relative_goal),
		.combined_mode (combined_mode),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.linear_speed  (linear_speed),
		.turn_rate     (turn_rate),
		.command_valid (command_valid),
		.task_status   (task_status)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.log_request(op_t'(operation), pos_x, pos_y, heading, goal_x, goal_y,
				goal_heading, relative_goal, combined_mode);
		if (out_valid && out_ready)
			sb.check_command(linear_speed, turn_rate, command_valid, task_status);
	end

	task automatic send(op_t op, logic signed [23:0] px, logic signed [23:0] py,
			logic signed [15:0] th, logic signed [23:0] gx, logic signed [23:0] gy,
			logic signed [15:0] gh, logic rel, logic cm);
		in_valid <= 1'b1;
		operation <= op;
		pos_x <= px;
		pos_y <= py;
		heading <= th;
		goal_x <= gx;
		goal_y <= gy;
		goal_heading <= gh;
		relative_goal <= rel;
		combined_mode <= cm;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		if (!steady && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_leg();
		logic signed [23:0] gx, gy, px, py, tx, ty;
		logic signed [15:0] gh, th, dir;
		bit rel, cm;
		int n, k, d, dx, dy;
		real a;
		if ($urandom_range(9) == 0) begin
			send(op_t'($urandom_range(3)), 24'($urandom), 24'($urandom), 16'($urandom),
				24'($urandom), 24'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
			return;
		end
		gx = 24'($urandom);
		gy = 24'($urandom);
		gh = 16'($urandom);
		px = 24'($urandom);
		py = 24'($urandom);
		th = 16'($urandom);
		rel = 1'($urandom_range(1));
		cm = 1'($urandom_range(1));
		send(OP_START, px, py, th, gx, gy, gh, rel, cm);
		tx = rel ? gx + px : gx;
		ty = rel ? gy + py : gy;
		n = $urandom_range(1, 12);
		repeat (n) begin
			if ($urandom_range(19) == 0) begin
				send($urandom_range(1) ? OP_STOP : OP_SPARE, 24'($urandom), 24'($urandom),
					16'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
					1'($urandom), 1'($urandom));
			end else begin
				k = ($urandom_range(9) < 4) ? 8 : $urandom_range(9, 24);
				d = int'($urandom_range(0, (1 << k) - 1));
				if ($urandom_range(2) == 0)
					dir = 16'(int'(gh) + int'($urandom_range(0, 600)) - 300);
				else
					dir = 16'($urandom);
				a = real'(dir) * PI / 32768.0;
				dx = $rtoi(d * $cos(a));
				dy = $rtoi(d * $sin(a));
				px = 24'(tx - dx);
				py = 24'(ty - dy);
				case ($urandom_range(2))
					0: th = 16'($urandom);
					1: th = 16'(int'(dir) + int'($urandom_range(0, 8000)) - 4000);
					default: th = 16'(int'(gh) + int'($urandom_range(0, 3000)) - 1500);
				endcase
				send(OP_POSE, px, py, th, 24'($urandom), 24'($urandom), 16'($urandom),
					1'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		int phase, goal, i;
		int unsigned v[7];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ARRIVE;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_START;
		pos_x = '0;
		pos_y = '0;
		heading = '0;
		goal_x = '0;
		goal_y = '0;
		goal_heading = '0;
		relative_goal = 1'b0;
		combined_mode = 1'b0;
		out_ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_POSE, 0, 0, 0, 0, 0, 0, 0, 0);
		send(OP_POSE, 1000, -500, 30000, 0, 0, 0, 0, 0);
		send(OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0);
		send(OP_SPARE, 24'h7FFFFF, 24'h800000, 16'h7FFF, 24'h7FFFFF, 24'h800000,
			16'h8000, 1, 1);
		send(OP_START, 0, 0, 0, 24'h7FFFFF, 24'h800000, 16'h8000, 0, 0);
		send(OP_POSE, 24'h800000, 24'h7FFFFF, 16'h7FFF, 0, 0, 0, 0, 0);
		send(OP_POSE, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0, 0);
		send(OP_POSE, 24'h7FFFFF, 24'h800000, -32768 + 1043, 0, 0, 0, 0, 0);
		send(OP_POSE, 24'h7FFFFF, 24'h800000, -32768 + 1044, 0, 0, 0, 0, 0);
		send(OP_START, 24'h7FFFFF, 24'h7FFFFF, 0, 24'h7FFFFF, 24'h7FFFFF, 16384, 1, 0);
		send(OP_POSE, 1998, -2, 16'h7FFF, 0, 0, 0, 0, 0);
		send(OP_POSE, -3002, -2, 3641, 0, 0, 0, 0, 0);
		send(OP_POSE, -3002, -2, 3640, 0, 0, 0, 0, 0);
		send(OP_POSE, -3002, -2, -3641, 0, 0, 0, 0, 0);
		send(OP_POSE, -2, -2, 16384 + 2000, 0, 0, 0, 0, 0);
		send(OP_START, 0, 0, 0, 0, 0, 0, 0, 1);
		send(OP_POSE, -50, 0, 0, 0, 0, 0, 0, 0);
		send(OP_POSE, 0, -50, 0, 0, 0, 0, 0, 0);
		send(OP_POSE, -5000, 0, 1000, 0, 0, 0, 0, 0);
		send(OP_POSE, 3000, 4000, -20000, 0, 0, 0, 0, 0);
		send(OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0);
		send(OP_START, -400000, 250000, 100, 3000, -3000, -16384, 1, 1);
		send(OP_POSE, -397000, 247000, -16384, 0, 0, 0, 0, 0);
		send(OP_POSE, -400000, 250000, 5000, 0, 0, 0, 0, 0);
		send(OP_POSE, 24'h800000, 24'h800000, 16'h8000, 0, 0, 0, 0, 0);

		for (phase = 0; phase < 8; phase++) begin
			in_valid <= 1'b0;
			wait_drained();
			if (phase > 0) begin
				case (phase)
					1: v = '{102, 256, 256, 300, 4096, 4096, 1043};
					2: v = '{8388607, 65535, 65535, 65535, 32767, 32767, 32767};
					3: v = '{0, 0, 0, 0, 0, 0, 0};
					default: begin
						v[0] = $urandom_range(0, 4000);
						for (i = 1; i < 4; i++) v[i] = $urandom_range(0, 65535);
						for (i = 4; i < 7; i++) v[i] = $urandom_range(0, 32767);
					end
				endcase
				for (i = 0; i < 7; i++) begin
					cfg_we <= 1'b1;
					cfg_index <= reg_idx_t'(i);
					cfg_data <= CFG_DAT_W'(v[i]);
					@(posedge clk);
					sb.set_reg(reg_idx_t'(i), 23'(v[i]));
				end
				cfg_we <= 1'b0;
			end
			steady = (phase == 4);
			goal = sent + 135;
			while (sent < goal) run_leg();
		end
		in_valid <= 1'b0;
		steady = 0;
		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[go_to_pose_steering] OK");
		else
			$display("[go_to_pose_steering] ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("[go_to_pose_steering] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/gtps_pkg.sv
hdl/gtps_mul.sv
hdl/gtps_cordic.sv
hdl/go_to_pose_steering.sv
bench/go_to_pose_steering_test.sv
